// ===== design/gauss_seidel_solver_top_assert.svh =====
// Assertion macros for the Gauss-Seidel solver top level.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef GAUSS_SEIDEL_SOLVER_TOP_ASSERT_SVH
`define GAUSS_SEIDEL_SOLVER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define GS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error("assertion failed");
`endif

// ===== design/gss_pkg.sv =====
// Shared types and constants of the Gauss-Seidel solver.
// Used by the divider and the top level; depends on nothing.
package gss_pkg;
	localparam logic [1:0] KIND_MATRIX = 2'd0;
	localparam logic [1:0] KIND_RHS    = 2'd1;
	localparam logic [1:0] KIND_GUESS  = 2'd2;
	localparam logic [1:0] KIND_START  = 2'd3;
	localparam logic [2:0] REG_MATRIX_SIZE = 3'd0;
	localparam logic [2:0] REG_SWEEP_COUNT = 3'd1;
	localparam int DIV_BITS = 64;
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctrl_t;
endpackage

// ===== design/gss_divider.sv =====
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on gss_pkg for the operand width and the control struct.
module gss_divider (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [gss_pkg::DIV_BITS-1:0] dividend,
	input  logic signed [31:0] divisor,
	output gss_pkg::div_ctrl_t ctrl,
	output logic signed [gss_pkg::DIV_BITS-1:0] quotient
);
	localparam int W = gss_pkg::DIV_BITS;
	logic [W-1:0] rem_q, quo_q;
	logic [31:0] den_q;
	logic neg_q, busy_q, done_q;
	logic [6:0] cnt_q;
	logic [W:0] trial;
	logic [W-1:0] shifted;

	assign shifted = {rem_q[W-2:0], quo_q[W-1]};
	assign trial = {1'b0, shifted} - {{(W-31){1'b0}}, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(W);
				rem_q <= '0;
				quo_q <= dividend[W-1] ? W'(-dividend) : W'(dividend);
				den_q <= divisor[31] ? 32'(-divisor) : 32'(divisor);
				neg_q <= dividend[W-1] ^ divisor[31];
			end else if (busy_q) begin
				quo_q <= {quo_q[W-2:0], ~trial[W]};
				rem_q <= trial[W] ? shifted : trial[W-1:0];
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
	assign ctrl = '{start: start, busy: busy_q, done: done_q};
endmodule

// ===== design/gauss_seidel_solver_top.sv =====
// Gauss-Seidel solver: loads a dense system entry by entry and solves it
// in place. Load transactions (matrix, right-hand side, initial guess) are
// taken one per cycle while the block is idle, and a load whose row, or for
// a matrix entry whose column, is not below MAX_SIZE is dropped. A start
// transaction first checks strict row diagonal dominance, reading each
// matrix entry in DOM_RD, adding it up in DOM_ACC and testing each row in
// DOM_ROW. Each row of a sweep then loads its diagonal (DIAG_RD, DIAG_LD)
// and runs one shared 64-bit serial divider per quotient. Each term is read
// in DIV_RD and divided in DIV_GO and DIV_WAIT; an off-diagonal quotient is
// multiplied by the current x and the product accumulated in MUL. The row
// is closed in ROW_END; the serial divider dominates the solve time. Each
// solution entry is then read in OUT_RD, registered in OUT_LD and held in
// OUT_SEND until m_tready takes it. Results saturate to Q16.16; a
// non-dominant matrix yields a single status transaction. The block is not
// ready while a start is in progress.
// Depends on gss_pkg, gss_divider and the assertion macro header.
`include "gauss_seidel_solver_top_assert.svh"
module gauss_seidel_solver_top #(
	parameter int MAX_SIZE = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata: row_index[3:0], col_index[7:4], entry_value[39:8]
	input  logic [39:0] s_tdata,
	// tuser: kind[1:0]
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// tdata: out_index[3:0], solution_value[35:4], zero fill [39:36]
	output logic [39:0] m_tdata,
	// tuser: status
	output logic m_tuser,
	output logic m_tlast,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);
	localparam int IW = (MAX_SIZE > 16) ? $clog2(MAX_SIZE) : 4;
	localparam int AW = 2 * IW;
	localparam int NMAX = (MAX_SIZE < 16) ? MAX_SIZE : 16;

	typedef enum logic [3:0] {
		IDLE, DOM_RD, DOM_ACC, DOM_ROW, DIAG_RD, DIAG_LD, DIV_RD, DIV_GO, DIV_WAIT, MUL,
		MUL_ACC, ROW_END, OUT_RD, OUT_LD, OUT_SEND
	} state_t;

	state_t state_q;
	logic [4:0] size_q;
	logic [7:0] sweeps_q;
	logic signed [31:0] mat_mem [2**AW];
	logic signed [31:0] rhs_mem [2**IW];
	logic signed [31:0] sol_mem [2**IW];
	logic signed [31:0] mat_rd_q, rhs_rd_q, sol_rd_q;
	logic [IW-1:0] i_q, j_q;
	logic [7:0] k_q;
	logic [4:0] n_q;
	logic [37:0] off_q;
	logic [31:0] dmag_q;
	logic signed [31:0] diag_q;
	logic signed [79:0] acc_q;
	logic signed [63:0] prod_q;
	logic signed [48:0] r_q;
	logic div_start;
	logic signed [63:0] div_num, div_quo;
	gss_pkg::div_ctrl_t div_ctrl;
	logic sol_we;
	logic [IW-1:0] sol_wa;
	logic signed [31:0] sol_wd;
	logic s_acc, m_acc;
	logic [IW-1:0] ld_row, ld_col;
	logic rng_ok, col_ok;
	logic [IW-1:0] rd_i, rd_j;
	logic signed [79:0] fl, xi;
	logic [31:0] mag_rd;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;
	assign s_tready = (state_q == IDLE);
	assign ld_row = IW'(s_tdata[3:0]);
	assign ld_col = IW'(s_tdata[7:4]);
	assign rng_ok = (32'(s_tdata[3:0]) < MAX_SIZE);
	assign col_ok = (32'(s_tdata[7:4]) < MAX_SIZE);
	assign mag_rd = mat_rd_q[31] ? 32'(-mat_rd_q) : 32'(mat_rd_q);

	// Address of the next matrix read; the diagonal is fetched at the start of a row.
	assign rd_i = i_q;
	assign rd_j = (state_q == DIAG_RD) ? i_q : j_q;

	always_ff @(posedge clk) begin
		if (s_acc && rng_ok) begin
			unique case (s_tuser)
				gss_pkg::KIND_MATRIX: if (col_ok) mat_mem[{ld_row, ld_col}] <= $signed(s_tdata[39:8]);
				gss_pkg::KIND_RHS:    rhs_mem[ld_row] <= $signed(s_tdata[39:8]);
				gss_pkg::KIND_GUESS:  ;
				gss_pkg::KIND_START:  ;
				default: ;
			endcase
		end
		if (sol_we) sol_mem[sol_wa] <= sol_wd;
		mat_rd_q <= mat_mem[AW'({rd_i, rd_j})];
		rhs_rd_q <= rhs_mem[rd_i];
		sol_rd_q <= sol_mem[rd_j];
	end

	// Floor of the Q32.32 sum to Q16.16, then subtract from r and saturate.
	assign fl = acc_q >>> 16;
	assign xi = 80'(r_q) - fl;

	always_comb begin
		sol_we = 1'b0;
		sol_wa = ld_row;
		sol_wd = $signed(s_tdata[39:8]);
		if (s_acc && rng_ok && s_tuser == gss_pkg::KIND_GUESS) begin
			sol_we = 1'b1;
		end else if (state_q == ROW_END) begin
			sol_we = 1'b1;
			sol_wa = i_q;
			if (xi > 80'sd2147483647) sol_wd = 32'sh7fffffff;
			else if (xi < -80'sd2147483648) sol_wd = 32'sh80000000;
			else sol_wd = xi[31:0];
		end
	end

	assign div_start = (state_q == DIV_GO);
	assign div_num = (j_q == i_q) ? 64'(rhs_rd_q) <<< 16 : 64'(mat_rd_q) <<< 16;

	gss_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(diag_q), .ctrl(div_ctrl), .quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			size_q <= 5'd4;
			sweeps_q <= 8'd10;
			m_tvalid <= 1'b0;
			m_tlast <= 1'b0;
			m_tuser <= 1'b0;
			m_tdata <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			n_q <= '0;
		end else begin
			if (cfg_we && cfg_index == gss_pkg::REG_MATRIX_SIZE) size_q <= cfg_data[4:0];
			if (cfg_we && cfg_index == gss_pkg::REG_SWEEP_COUNT) sweeps_q <= cfg_data;
			unique case (state_q)
				IDLE: begin
					if (s_acc && s_tuser == gss_pkg::KIND_START) begin
						if (size_q == 5'd0) n_q <= 5'd1;
						else if (size_q > 5'(NMAX)) n_q <= 5'(NMAX);
						else n_q <= size_q;
						i_q <= '0;
						j_q <= '0;
						off_q <= '0;
						state_q <= DOM_RD;
					end
				end
				DOM_RD: state_q <= DOM_ACC;
				DOM_ACC: begin
					if (j_q == i_q) dmag_q <= mag_rd;
					else off_q <= off_q + 38'(mag_rd);
					if (5'(j_q) == n_q - 5'd1) state_q <= DOM_ROW;
					else begin
						j_q <= j_q + IW'(1);
						state_q <= DOM_RD;
					end
				end
				DOM_ROW: begin
					j_q <= '0;
					off_q <= '0;
					if (38'(dmag_q) <= off_q) begin
						m_tvalid <= 1'b1;
						m_tuser <= 1'b1;
						m_tlast <= 1'b1;
						m_tdata <= '0;
						state_q <= OUT_SEND;
					end else if (5'(i_q) == n_q - 5'd1) begin
						i_q <= '0;
						k_q <= '0;
						j_q <= '0;
						state_q <= (sweeps_q == 8'd0) ? OUT_RD : DIAG_RD;
					end else begin
						i_q <= i_q + IW'(1);
						state_q <= DOM_RD;
					end
				end
				// The diagonal of the row is read and held as the divisor.
				DIAG_RD: state_q <= DIAG_LD;
				DIAG_LD: state_q <= DIV_RD;
				// Read a[i][j] (or b[i] when j equals i) then divide.
				DIV_RD: begin
					acc_q <= (j_q == '0) ? '0 : acc_q;
					state_q <= DIV_GO;
				end
				DIV_GO: state_q <= DIV_WAIT;
				DIV_WAIT: if (div_ctrl.done) begin
					if (j_q == i_q) begin
						r_q <= div_quo[48:0];
						state_q <= MUL_ACC;
					end else begin
						prod_q <= $signed(div_quo[16:0]) * sol_rd_q;
						state_q <= MUL;
					end
				end
				MUL: begin
					acc_q <= acc_q + 80'(prod_q);
					state_q <= MUL_ACC;
				end
				MUL_ACC: begin
					if (5'(j_q) == n_q - 5'd1) state_q <= ROW_END;
					else begin
						j_q <= j_q + IW'(1);
						state_q <= DIV_RD;
					end
				end
				ROW_END: begin
					j_q <= '0;
					if (5'(i_q) == n_q - 5'd1) begin
						i_q <= '0;
						if (k_q == sweeps_q - 8'd1) state_q <= OUT_RD;
						else begin
							k_q <= k_q + 8'd1;
							state_q <= DIAG_RD;
						end
					end else begin
						i_q <= i_q + IW'(1);
						state_q <= DIAG_RD;
					end
				end
				// The solution entry is read here, registered in OUT_LD and presented in OUT_SEND.
				OUT_RD: state_q <= OUT_LD;
				OUT_LD: begin
					m_tvalid <= 1'b1;
					m_tuser <= 1'b0;
					m_tlast <= (5'(j_q) == n_q - 5'd1);
					m_tdata <= {4'd0, sol_rd_q, 4'(j_q)};
					state_q <= OUT_SEND;
				end
				OUT_SEND: if (m_acc) begin
					m_tvalid <= 1'b0;
					if (m_tlast) state_q <= IDLE;
					else begin
						j_q <= j_q + IW'(1);
						state_q <= OUT_RD;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// Divisor register: the diagonal of the current row, loaded before its divisions.
	always_ff @(posedge clk) begin
		if (state_q == DIAG_LD) diag_q <= mat_rd_q;
	end

	`GS_ASSERT_IMP(a_out_idle_ready, clk, arst_n, m_tvalid, !s_tready)
	`GS_ASSERT_NEXT(a_div_start_busy, clk, arst_n, div_ctrl.start, div_ctrl.busy)
	`GS_ASSERT_IMP(a_status_last, clk, arst_n, m_tvalid && m_tuser, m_tlast)
endmodule
